### sv/ycr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_pkg - shared types and constants for the 4:2:2 YCbCr to RGB converter
// Q10 BT.601 coefficients, offsets, accumulator types and the output clamp.
// ----------------------------------------------------------------------------
package ycr_pkg;

  localparam int AccW = 22;
  localparam int DiffW = 10;
  localparam int QShift = 10;
  localparam int PixW = 8;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic [PixW-1:0]         pix_t;

  localparam diff_t LUMA_OFF   = 10'sd14;
  localparam diff_t CHROMA_OFF = 10'sd128;

  localparam acc_t K_LUMA    = 22'sd1192;
  localparam acc_t K_CR_TO_R = 22'sd1634;
  localparam acc_t K_CR_TO_G = 22'sd833;
  localparam acc_t K_CB_TO_G = 22'sd401;
  localparam acc_t K_CB_TO_B = 22'sd2065;

  // chroma contributions shared by both pixels of a word
  typedef struct packed {
    acc_t b_term;
    acc_t g_term;
    acc_t r_term;
  } chroma_t;

  // floor by the Q shift, then saturate to 0..255
  function automatic pix_t clamp_pix(input acc_t acc);
    pix_t res;
    res = '0;
    if (acc[AccW-1]) begin
      res = '0;
    end else if (|acc[AccW-2:QShift+PixW]) begin
      res = '1;
    end else begin
      res = acc[QShift+PixW-1:QShift];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### sv/ycr_pixel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_pixel - one pixel of the converter
// Scaled luma plus shared B/R chroma terms, less the G term; clamps B, G, R.
// ----------------------------------------------------------------------------
module ycr_pixel
  import ycr_pkg::*;
(
  input  wire logic [7:0] luma,
  input  wire chroma_t    chroma,
  output pix_t            blue,
  output pix_t            green,
  output pix_t            red
);

  diff_t lum_d;
  acc_t  lum_term;

  assign lum_d    = diff_t'({2'b00, luma}) - LUMA_OFF;
  assign lum_term = acc_t'(lum_d) * K_LUMA;

  assign blue  = clamp_pix(lum_term + chroma.b_term);
  assign green = clamp_pix(lum_term - chroma.g_term);
  assign red   = clamp_pix(lum_term + chroma.r_term);

endmodule
`default_nettype wire

### sv/ycbcr422_to_rgb32.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycbcr422_to_rgb32 - packed 4:2:2 YCbCr word to two BGR pixels
// Each input word (Cb, Y0, Cr, Y1) is captured in an input register, converted
// with Q10 BT.601 coefficients in one pass of logic and held in a result
// register. The block takes one word per clock while the result side does not
// stall; the conversion is a single register-to-register path. Stall on
// the result side propagates to in_stall only once both registers are full.
// ----------------------------------------------------------------------------
module ycbcr422_to_rgb32
  import ycr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_cb_in,
  input  wire logic [7:0] in_y_first,
  input  wire logic [7:0] in_cr_in,
  input  wire logic [7:0] in_y_second,
  input  wire logic       in_last_group_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_blue_first,
  output logic [7:0]      out_green_first,
  output logic [7:0]      out_red_first,
  output logic [7:0]      out_blue_second,
  output logic [7:0]      out_green_second,
  output logic [7:0]      out_red_second,
  output logic            out_last_group_out
);

  logic       s1_v_r, s1_v_nxt;
  logic [7:0] cb_r, y0_r, cr_r, y1_r;
  logic       last_r;
  logic       out_v_r, out_v_nxt;
  pix_t       b0_r, g0_r, r0_r, b1_r, g1_r, r1_r;
  logic       last_out_r;

  logic    s2_load;
  logic    s1_load;
  diff_t   cb_d, cr_d;
  chroma_t chroma;
  pix_t    b0, g0, r0, b1, g1, r1;

  assign s2_load  = !out_v_r || !out_stall;
  assign s1_load  = !s1_v_r || s2_load;
  assign in_stall = !s1_load;

  assign s1_v_nxt  = s1_load ? in_valid : s1_v_r;
  assign out_v_nxt = s2_load ? s1_v_r : out_v_r;

  assign cb_d = diff_t'({2'b00, cb_r}) - CHROMA_OFF;
  assign cr_d = diff_t'({2'b00, cr_r}) - CHROMA_OFF;

  assign chroma.b_term = acc_t'(cb_d) * K_CB_TO_B;
  assign chroma.g_term = acc_t'(cr_d) * K_CR_TO_G + acc_t'(cb_d) * K_CB_TO_G;
  assign chroma.r_term = acc_t'(cr_d) * K_CR_TO_R;

  ycr_pixel u_pix0 (
    .luma   (y0_r),
    .chroma (chroma),
    .blue   (b0),
    .green  (g0),
    .red    (r0)
  );

  ycr_pixel u_pix1 (
    .luma   (y1_r),
    .chroma (chroma),
    .blue   (b1),
    .green  (g1),
    .red    (r1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      cb_r   <= in_cb_in;
      y0_r   <= in_y_first;
      cr_r   <= in_cr_in;
      y1_r   <= in_y_second;
      last_r <= in_last_group_in;
    end
  end

  // advance the converted word
  always_ff @(posedge clk) begin
    if (s2_load && s1_v_r) begin
      b0_r       <= b0;
      g0_r       <= g0;
      r0_r       <= r0;
      b1_r       <= b1;
      g1_r       <= g1;
      r1_r       <= r1;
      last_out_r <= last_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_blue_first     = b0_r;
  assign out_green_first    = g0_r;
  assign out_red_first      = r0_r;
  assign out_blue_second    = b1_r;
  assign out_green_second   = g1_r;
  assign out_red_second     = r1_r;
  assign out_last_group_out = last_out_r;

endmodule
`default_nettype wire

### sv/ycr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_checker - port-level checks for the YCbCr to RGB converter
// Watches both channels over time and reports violations.
// ----------------------------------------------------------------------------
module ycr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_blue_first,
  input wire logic [7:0] out_red_second,
  input wire logic       out_last_group_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_blue_first) && $stable(out_red_second)
      && $stable(out_last_group_out))
    else $error("stalled result word changed");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted word did not reach the output in time");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule

bind ycbcr422_to_rgb32 ycr_checker u_ycr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_blue_first     (out_blue_first),
  .out_red_second     (out_red_second),
  .out_last_group_out (out_last_group_out)
);
`default_nettype wire

### tb/ycbcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr_checker - word predictor and result comparator for ycbcr422_to_rgb32
// Watches both channels. Every accepted input word is converted to its two
// expected BGR pixels and queued. Every accepted result word is compared field
// by field with the oldest queued word. Failures and the queue depth go to
// the testbench top.
// ----------------------------------------------------------------------------
module ycbcr_checker
  import ycr_pkg::pix_t;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_cb_in,
  input  wire logic [7:0] in_y_first,
  input  wire logic [7:0] in_cr_in,
  input  wire logic [7:0] in_y_second,
  input  wire logic       in_last_group_in,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_blue_first,
  input  wire logic [7:0] out_green_first,
  input  wire logic [7:0] out_red_first,
  input  wire logic [7:0] out_blue_second,
  input  wire logic [7:0] out_green_second,
  input  wire logic [7:0] out_red_second,
  input  wire logic       out_last_group_out,
  output int              fail_count,
  output int              pending_words
);

  localparam int LUMA_BIAS   = 14;
  localparam int CHROMA_BIAS = 128;
  localparam int COEF_Y      = 1192;
  localparam int COEF_CR_R   = 1634;
  localparam int COEF_CR_G   = 833;
  localparam int COEF_CB_G   = 401;
  localparam int COEF_CB_B   = 2065;
  localparam int FRAC_BITS   = 10;
  localparam int PIX_CEIL    = 255;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    pix_t blue_a;
    pix_t green_a;
    pix_t red_a;
    pix_t blue_b;
    pix_t green_b;
    pix_t red_b;
    logic last;
  } bgr_pair_t;

  bgr_pair_t bgr_expected_q[$];
  int        mismatch_reports;

  function automatic pix_t saturate_q10(input int acc);
    int whole;
    if (acc < 0) return '0;
    whole = acc >>> FRAC_BITS;
    if (whole > PIX_CEIL) return pix_t'(PIX_CEIL);
    return pix_t'(whole);
  endfunction

  function automatic bgr_pair_t convert_group(input logic [7:0] cb, input logic [7:0] y0,
                                              input logic [7:0] cr, input logic [7:0] y1,
                                              input logic last);
    int        du;
    int        dv;
    int        l0;
    int        l1;
    bgr_pair_t w;
    du = int'(cb) - CHROMA_BIAS;
    dv = int'(cr) - CHROMA_BIAS;
    l0 = COEF_Y * (int'(y0) - LUMA_BIAS);
    l1 = COEF_Y * (int'(y1) - LUMA_BIAS);
    w.blue_a  = saturate_q10(l0 + COEF_CB_B * du);
    w.green_a = saturate_q10(l0 - COEF_CR_G * dv - COEF_CB_G * du);
    w.red_a   = saturate_q10(l0 + COEF_CR_R * dv);
    w.blue_b  = saturate_q10(l1 + COEF_CB_B * du);
    w.green_b = saturate_q10(l1 - COEF_CR_G * dv - COEF_CB_G * du);
    w.red_b   = saturate_q10(l1 + COEF_CR_R * dv);
    w.last    = last;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (mismatch_reports < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      end
      mismatch_reports++;
    end
  endtask

  always @(posedge clk) begin
    bgr_pair_t want;
    if (!rst_n) begin
      bgr_expected_q.delete();
      fail_count       = 0;
      mismatch_reports = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bgr_expected_q.size() == 0) begin
          fail_count++;
          if (mismatch_reports < MAX_REPORTS) begin
            $display("%0t: result word with nothing expected", $time);
          end
          mismatch_reports++;
        end else begin
          want = bgr_expected_q.pop_front();
          check_field("blue_first",   want.blue_a,  out_blue_first);
          check_field("green_first",  want.green_a, out_green_first);
          check_field("red_first",    want.red_a,   out_red_first);
          check_field("blue_second",  want.blue_b,  out_blue_second);
          check_field("green_second", want.green_b, out_green_second);
          check_field("red_second",   want.red_b,   out_red_second);
          check_field("last_group",   {7'd0, want.last}, {7'd0, out_last_group_out});
        end
      end
      if (in_valid && !in_stall) begin
        bgr_expected_q.push_back(convert_group(in_cb_in, in_y_first, in_cr_in,
                                               in_y_second, in_last_group_in));
      end
    end
    pending_words = bgr_expected_q.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for ycbcr422_to_rgb32
// Sends directed extreme and black/white/saturating words, then randomized
// words under rotating sender-idle and receiver-stall mixes, including one
// long receiver hold-off that backs the block up. A separate checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int CHUNKS       = 8;
  localparam int CHUNK_WORDS  = 138;
  localparam int TAIL_CYCLES  = 8;
  localparam logic [7:0] BYTE_MIN   = 8'd0;
  localparam logic [7:0] BYTE_MAX   = 8'd255;
  localparam logic [7:0] LUMA_BLACK = 8'd14;
  localparam logic [7:0] CHROMA_MID = 8'd128;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_cb_in;
  logic [7:0] in_y_first;
  logic [7:0] in_cr_in;
  logic [7:0] in_y_second;
  logic       in_last_group_in;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_blue_first;
  logic [7:0] out_green_first;
  logic [7:0] out_red_first;
  logic [7:0] out_blue_second;
  logic [7:0] out_green_second;
  logic [7:0] out_red_second;
  logic       out_last_group_out;
  int         fail_count;
  int         pending_words;
  int         idle_pct;
  int         stall_pct;
  int         cycle_count;
  logic       hold_go;
  logic       hold_done;

  ycbcr422_to_rgb32 u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cb_in          (in_cb_in),
    .in_y_first        (in_y_first),
    .in_cr_in          (in_cr_in),
    .in_y_second       (in_y_second),
    .in_last_group_in  (in_last_group_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_blue_first    (out_blue_first),
    .out_green_first   (out_green_first),
    .out_red_first     (out_red_first),
    .out_blue_second   (out_blue_second),
    .out_green_second  (out_green_second),
    .out_red_second    (out_red_second),
    .out_last_group_out(out_last_group_out)
  );

  ycbcr_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cb_in          (in_cb_in),
    .in_y_first        (in_y_first),
    .in_cr_in          (in_cr_in),
    .in_y_second       (in_y_second),
    .in_last_group_in  (in_last_group_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_blue_first    (out_blue_first),
    .out_green_first   (out_green_first),
    .out_red_first     (out_red_first),
    .out_blue_second   (out_blue_second),
    .out_green_second  (out_green_second),
    .out_red_second    (out_red_second),
    .out_last_group_out(out_last_group_out),
    .fail_count        (fail_count),
    .pending_words     (pending_words)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[ycbcr422_to_rgb32] ERROR");
      $finish;
    end
  end

  // receiver: random stall, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return BYTE_MIN;
      1: return BYTE_MAX;
      2: return LUMA_BLACK + 8'($urandom_range(0, 3)) - 8'd2;
      3: return CHROMA_MID + 8'($urandom_range(0, 15)) - 8'd8;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_group(input logic [7:0] cb, input logic [7:0] y0,
                            input logic [7:0] cr, input logic [7:0] y1,
                            input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid         <= 1'b0;
      in_cb_in         <= 8'($urandom);
      in_y_first       <= 8'($urandom);
      in_cr_in         <= 8'($urandom);
      in_y_second      <= 8'($urandom);
      in_last_group_in <= 1'($urandom);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_cb_in         <= cb;
    in_y_first       <= y0;
    in_cr_in         <= cr;
    in_y_second      <= y1;
    in_last_group_in <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cb_in         = '0;
    in_y_first       = '0;
    in_cr_in         = '0;
    in_y_second      = '0;
    in_last_group_in = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_go          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes, black, white, negative and saturating sums, bit patterns
    send_group(BYTE_MIN, BYTE_MIN, BYTE_MIN, BYTE_MIN, 1'b0);
    send_group(BYTE_MAX, BYTE_MAX, BYTE_MAX, BYTE_MAX, 1'b1);
    send_group(CHROMA_MID, LUMA_BLACK, CHROMA_MID, LUMA_BLACK, 1'b0);
    send_group(CHROMA_MID, 8'd235, CHROMA_MID, BYTE_MAX, 1'b0);
    send_group(CHROMA_MID, BYTE_MIN, CHROMA_MID, 8'd13, 1'b1);
    send_group(BYTE_MIN, CHROMA_MID, BYTE_MIN, CHROMA_MID, 1'b0);
    send_group(BYTE_MAX, CHROMA_MID, BYTE_MAX, CHROMA_MID, 1'b0);
    send_group(BYTE_MIN, BYTE_MAX, BYTE_MAX, BYTE_MIN, 1'b1);
    send_group(BYTE_MAX, BYTE_MIN, BYTE_MIN, BYTE_MAX, 1'b0);
    send_group(BYTE_MAX, LUMA_BLACK, BYTE_MIN, 8'd15, 1'b0);
    send_group(BYTE_MIN, 8'd200, BYTE_MAX, 8'd60, 1'b1);
    send_group(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
    send_group(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);
    send_group(8'd90, 8'd81, 8'd240, 8'd145, 1'b0);
    send_group(8'd240, 8'd41, 8'd110, 8'd210, 1'b0);
    send_group(8'd16, 8'd235, 8'd16, 8'd16, 1'b1);

    for (int c = 0; c < CHUNKS; c++) begin
      case (c % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 45;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 45;
        end
        default: begin
          idle_pct  = 16;
          stall_pct = 16;
        end
      endcase
      if (c == 0) hold_go = 1'b1;
      for (int i = 0; i < CHUNK_WORDS; i++) begin
        send_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                   ($urandom_range(0, 15) == 0));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("[ycbcr422_to_rgb32] OK");
    end else begin
      $display("[ycbcr422_to_rgb32] ERROR");
    end
    $finish;
  end

endmodule
